/* rtl/lrc_pkg.sv */
// ============================================================================
// lrc_pkg
// Shared types and constants for the clipped line rasterizer.
// ============================================================================
`default_nettype none

package lrc_pkg;

    localparam logic [12:0] MAX_DIM = 13'd4096;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] REG_SURFACE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SURFACE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DEST_FORMAT    = 3'd2;
    localparam logic [2:0] REG_SOURCE_ORDER   = 3'd3;
    localparam logic [2:0] REG_DRAW_COLOR     = 3'd4;
    localparam logic [2:0] REG_PALETTE_INDEX  = 3'd5;

    localparam logic [2:0] FMT_INDEX8 = 3'd0;
    localparam logic [2:0] FMT_RGB24  = 3'd1;
    localparam logic [2:0] FMT_BGR24  = 3'd2;
    localparam logic [2:0] FMT_RGBA32 = 3'd3;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
    } pixel_t;

    typedef struct packed {
        logic [12:0] surface_width;
        logic [12:0] surface_height;
        logic [2:0]  dest_format;
        logic        source_order;
        logic [31:0] draw_color;
        logic [7:0]  palette_index;
    } cfg_t;

endpackage

`default_nettype wire

/* rtl/lrc_front.sv */
// ============================================================================
// lrc_front
// Line walker: loads endpoints, takes one error step per advance transaction and
// hands each produced pixel to the queue.
// ============================================================================
`default_nettype none

module lrc_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic                 command,
    input  wire logic signed [15:0]   x_start,
    input  wire logic signed [15:0]   y_start,
    input  wire logic signed [15:0]   x_end,
    input  wire logic signed [15:0]   y_end,
    output      logic                 pix_valid,
    output      lrc_pkg::pixel_t      pix
);
    import lrc_pkg::*;

    logic signed [15:0] cur_x_reg, cur_x_next;
    logic signed [15:0] cur_y_reg, cur_y_next;
    logic signed [15:0] tgt_x_reg, tgt_x_next;
    logic signed [15:0] tgt_y_reg, tgt_y_next;
    logic [16:0]        span_x_reg, span_x_next;
    logic [16:0]        span_y_reg, span_y_next;
    logic signed [17:0] err_reg, err_next;
    logic               left_reg, left_next;
    logic               up_reg, up_next;
    logic               finished_reg, finished_next;

    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [18:0] e2;
    logic signed [18:0] sx_ext;
    logic signed [18:0] sy_ext;
    logic signed [18:0] err_sum;
    logic               step_x;
    logic               step_y;
    logic               emit;

    always_comb
    begin
        dx = $signed({x_end[15], x_end}) - $signed({x_start[15], x_start});
        dy = $signed({y_end[15], y_end}) - $signed({y_start[15], y_start});
        e2 = $signed({err_reg, 1'b0});
        sx_ext = $signed({2'b00, span_x_reg});
        sy_ext = $signed({2'b00, span_y_reg});
        step_x = e2 > -sy_ext;
        step_y = e2 < sx_ext;
        err_sum = $signed({err_reg[17], err_reg})
                  - (step_x ? sy_ext : 19'sd0)
                  + (step_y ? sx_ext : 19'sd0);

        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        tgt_x_next    = tgt_x_reg;
        tgt_y_next    = tgt_y_reg;
        span_x_next   = span_x_reg;
        span_y_next   = span_y_reg;
        err_next      = err_reg;
        left_next     = left_reg;
        up_next       = up_reg;
        finished_next = finished_reg;
        emit          = 1'b0;

        if (command == CMD_START)
        begin
            emit        = 1'b1;
            cur_x_next  = x_start;
            cur_y_next  = y_start;
            tgt_x_next  = x_end;
            tgt_y_next  = y_end;
            span_x_next = dx[16] ? 17'(-dx) : 17'(dx);
            span_y_next = dy[16] ? 17'(-dy) : 17'(dy);
            left_next   = !(x_start < x_end);
            up_next     = !(y_start < y_end);
            err_next    = $signed({1'b0, span_x_next}) - $signed({1'b0, span_y_next});
        end
        else if (!finished_reg)
        begin
            emit = 1'b1;
            if (step_x)
            begin
                cur_x_next = left_reg ? cur_x_reg - 16'sd1 : cur_x_reg + 16'sd1;
            end
            if (step_y)
            begin
                cur_y_next = up_reg ? cur_y_reg - 16'sd1 : cur_y_reg + 16'sd1;
            end
            err_next = err_sum[17:0];
        end

        if (emit)
        begin
            finished_next = (cur_x_next == tgt_x_next) && (cur_y_next == tgt_y_next);
        end

        pix_valid = accept && emit;
        pix.x     = cur_x_next;
        pix.y     = cur_y_next;
        pix.last  = finished_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            tgt_x_reg    <= '0;
            tgt_y_reg    <= '0;
            span_x_reg   <= '0;
            span_y_reg   <= '0;
            err_reg      <= '0;
            left_reg     <= 1'b0;
            up_reg       <= 1'b0;
            finished_reg <= 1'b1;
        end
        else if (accept)
        begin
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            tgt_x_reg    <= tgt_x_next;
            tgt_y_reg    <= tgt_y_next;
            span_x_reg   <= span_x_next;
            span_y_reg   <= span_y_next;
            err_reg      <= err_next;
            left_reg     <= left_next;
            up_reg       <= up_next;
            finished_reg <= finished_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/lrc_queue.sv */
// ============================================================================
// lrc_queue
// Short pixel queue between the line walker and the pixel formatter.
// ============================================================================
`default_nettype none

module lrc_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire lrc_pkg::pixel_t wr_data,
    input  wire logic            rd_en,
    output      lrc_pkg::pixel_t rd_data,
    output      logic            full,
    output      logic            not_empty
);
    import lrc_pkg::*;

    pixel_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign full      = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign rd_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (!full || rd_en))
        else $error("queue write while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> not_empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

/* rtl/lrc_back.sv */
// ============================================================================
// lrc_back
// Pixel formatter: clips, packs color bytes and computes the byte offset
// in two stages ending in the result register.
// ============================================================================
`default_nettype none

module lrc_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lrc_pkg::cfg_t   cfg,
    input  wire logic            in_valid,
    input  wire lrc_pkg::pixel_t in_pix,
    output      logic            in_ready,
    input  wire logic            pop,
    output      logic            empty,
    output      logic [25:0]     byte_offset,
    output      logic [31:0]     pixel_bytes,
    output      logic [2:0]      byte_count,
    output      logic            write_enable,
    output      logic signed [15:0] pixel_x,
    output      logic signed [15:0] pixel_y,
    output      logic            last
);
    import lrc_pkg::*;

    logic               s1_valid_reg;
    logic [24:0]        s1_prod_reg;
    logic [11:0]        s1_col_reg;
    logic               s1_wen_reg;
    logic [31:0]        s1_bytes_reg;
    logic [2:0]         s1_count_reg;
    pixel_t             s1_pix_reg;

    logic               out_valid_reg;
    logic               out_ready;

    logic [12:0]        w_sat;
    logic [12:0]        h_sat;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic [7:0]         a;
    logic [31:0]        bytes;
    logic [2:0]         count;
    logic               fmt_ok;
    logic               on_surface;
    logic [25:0]        lin;
    logic [25:0]        off;

    assign out_ready = !out_valid_reg || pop;
    assign in_ready  = !s1_valid_reg || out_ready;
    assign empty     = !out_valid_reg;

    always_comb
    begin
        w_sat = (cfg.surface_width > MAX_DIM) ? MAX_DIM : cfg.surface_width;
        h_sat = (cfg.surface_height > MAX_DIM) ? MAX_DIM : cfg.surface_height;
        r = cfg.source_order ? cfg.draw_color[23:16] : cfg.draw_color[7:0];
        g = cfg.draw_color[15:8];
        b = cfg.source_order ? cfg.draw_color[7:0] : cfg.draw_color[23:16];
        a = cfg.draw_color[31:24];
        fmt_ok = 1'b1;
        case (cfg.dest_format)
            FMT_INDEX8:
            begin
                bytes = {24'd0, cfg.palette_index};
                count = 3'd1;
            end
            FMT_RGB24:
            begin
                bytes = {8'd0, b, g, r};
                count = 3'd3;
            end
            FMT_BGR24:
            begin
                bytes = {8'd0, r, g, b};
                count = 3'd3;
            end
            FMT_RGBA32:
            begin
                bytes = {a, b, g, r};
                count = 3'd4;
            end
            default:
            begin
                bytes  = '0;
                count  = 3'd1;
                fmt_ok = 1'b0;
            end
        endcase
        on_surface = !in_pix.x[15] && !in_pix.y[15]
                     && ({1'b0, in_pix.x[14:0]} < {3'b000, w_sat})
                     && ({1'b0, in_pix.y[14:0]} < {3'b000, h_sat});
    end

    always_comb
    begin
        lin = {1'b0, s1_prod_reg} + {14'd0, s1_col_reg};
        case (s1_count_reg)
            3'd3:    off = lin + {lin[24:0], 1'b0};
            3'd4:    off = {lin[23:0], 2'b00};
            default: off = lin;
        endcase
        if (!s1_wen_reg)
        begin
            off = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_prod_reg  <= w_sat[12:0] * in_pix.y[11:0];
            s1_col_reg   <= in_pix.x[11:0];
            s1_wen_reg   <= fmt_ok && on_surface;
            s1_bytes_reg <= bytes;
            s1_count_reg <= count;
            s1_pix_reg   <= in_pix;
        end
        if (s1_valid_reg && out_ready)
        begin
            byte_offset  <= off;
            pixel_bytes  <= s1_bytes_reg;
            byte_count   <= s1_count_reg;
            write_enable <= s1_wen_reg;
            pixel_x      <= s1_pix_reg.x;
            pixel_y      <= s1_pix_reg.y;
            last         <= s1_pix_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    a_off_zero_when_masked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !write_enable) |-> (byte_offset == '0))
        else $error("masked pixel carries an offset");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_ready) |=> (s1_valid_reg && $stable(s1_pix_reg)))
        else $error("stage one lost a stalled pixel");

    a_no_accept_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !pop) |-> !in_ready)
        else $error("formatter took a pixel while stalled");

endmodule

`default_nettype wire

/* rtl/line_rasterizer_clipped_top.sv */
// ============================================================================
// line_rasterizer_clipped_top
// Clipped Bresenham line rasterizer with queue-style command and pixel ports.
// ============================================================================
// Throughput: one transaction per cycle on the input side while full is low and on the
// output side while pop is high, one error step per cycle while advances are accepted.
// Pixels pass from the line walker through the pixel queue and two formatter stages.
// Reset: no line active, queue and pipeline empty, registers at 640, 480, rgba32.
`default_nettype none

module line_rasterizer_clipped_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output      logic                full,
    input  wire logic                command,
    input  wire logic signed [15:0]  x_start,
    input  wire logic signed [15:0]  y_start,
    input  wire logic signed [15:0]  x_end,
    input  wire logic signed [15:0]  y_end,
    input  wire logic                pop,
    output      logic                empty,
    output      logic [25:0]         byte_offset,
    output      logic [31:0]         pixel_bytes,
    output      logic [2:0]          byte_count,
    output      logic                write_enable,
    output      logic signed [15:0]  pixel_x,
    output      logic signed [15:0]  pixel_y,
    output      logic                last,
    input  wire logic                cfg_valid,
    output      logic                cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);
    import lrc_pkg::*;

    cfg_t   cfg_reg;
    logic   accept;
    logic   pix_valid;
    pixel_t pix;
    pixel_t q_data;
    logic   q_not_empty;
    logic   back_ready;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.surface_width  <= 13'd640;
            cfg_reg.surface_height <= 13'd480;
            cfg_reg.dest_format    <= FMT_RGBA32;
            cfg_reg.source_order   <= 1'b0;
            cfg_reg.draw_color     <= '0;
            cfg_reg.palette_index  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SURFACE_WIDTH:  cfg_reg.surface_width  <= cfg_data[12:0];
                REG_SURFACE_HEIGHT: cfg_reg.surface_height <= cfg_data[12:0];
                REG_DEST_FORMAT:    cfg_reg.dest_format    <= cfg_data[2:0];
                REG_SOURCE_ORDER:   cfg_reg.source_order   <= cfg_data[0];
                REG_DRAW_COLOR:     cfg_reg.draw_color     <= cfg_data;
                REG_PALETTE_INDEX:  cfg_reg.palette_index  <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    lrc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .command   (command),
        .x_start   (x_start),
        .y_start   (y_start),
        .x_end     (x_end),
        .y_end     (y_end),
        .pix_valid (pix_valid),
        .pix       (pix)
    );

    lrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (pix_valid),
        .wr_data   (pix),
        .rd_en     (q_not_empty && back_ready),
        .rd_data   (q_data),
        .full      (full),
        .not_empty (q_not_empty)
    );

    lrc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (q_not_empty),
        .in_pix       (q_data),
        .in_ready     (back_ready),
        .pop          (pop),
        .empty        (empty),
        .byte_offset  (byte_offset),
        .pixel_bytes  (pixel_bytes),
        .byte_count   (byte_count),
        .write_enable (write_enable),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .last         (last)
    );

endmodule

`default_nettype wire

/* test/line_rasterizer_clipped_top_tb.sv */
// ============================================================================
// line_rasterizer_clipped_top_tb
// Self-checking bench for the clipped Bresenham line rasterizer. A short
// directed table covers endpoint extremes, clipping, every surface format,
// color swap, size saturation and dropped lines; random line sequences then
// run under several register settings with bursty input and a stalling pixel
// sink. Every popped pixel is compared with a local line-walk predictor or with the
// expected word given in its table row.
`timescale 1ns / 1ps

module line_rasterizer_clipped_top_tb;

    import lrc_pkg::*;

    localparam int CLK_PERIOD       = 4;
    localparam int RESET_CYCLES     = 12;
    localparam int SETTLE_CYCLES    = 8;
    localparam int HOLD_CYCLES      = 400;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int NUM_PHASES       = 6;
    localparam int PIXELS_PER_PHASE = 300;
    localparam int MAX_REPORTS      = 10;

    localparam logic [2:0] FMT_NONE     = 3'd4;
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [25:0]        byte_offset;
        logic [31:0]        pixel_bytes;
        logic [2:0]         byte_count;
        logic               write_enable;
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic               last;
    } pixel_word_t;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [2:0]         reg_index;
        logic [31:0]        reg_data;
        logic               cmd;
        logic signed [15:0] xs;
        logic signed [15:0] ys;
        logic signed [15:0] xe;
        logic signed [15:0] ye;
        bit                 typed;
        pixel_word_t        want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic               command;
    logic signed [15:0] x_start;
    logic signed [15:0] y_start;
    logic signed [15:0] x_end;
    logic signed [15:0] y_end;
    logic               pop;
    logic               empty;
    logic [25:0]        byte_offset;
    logic [31:0]        pixel_bytes;
    logic [2:0]         byte_count;
    logic               write_enable;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               last;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    // line walker state and register shadow
    int   walk_x;
    int   walk_y;
    int   walk_tx;
    int   walk_ty;
    int   span_x;
    int   span_y;
    int   err_term;
    bit   step_left;
    bit   step_up;
    bit   line_done;
    cfg_t shadow_cfg;

    pixel_word_t pixel_expect_q[$];
    stim_row_t   directed_rows[$];

    int burst_left;
    int hold_left;
    bit hold_request;
    int mode_left;
    int pop_mode;
    int idle_cycles;
    int fail_count;
    int lines_started;
    int pixels_expected;
    int pixels_checked;
    int pixels_written;
    int full_stalls;

    line_rasterizer_clipped_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .command      (command),
        .x_start      (x_start),
        .y_start      (y_start),
        .x_end        (x_end),
        .y_end        (y_end),
        .pop          (pop),
        .empty        (empty),
        .byte_offset  (byte_offset),
        .pixel_bytes  (pixel_bytes),
        .byte_count   (byte_count),
        .write_enable (write_enable),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic pixel_word_t pixel_word(input logic [25:0] off, input logic [31:0] bytes,
                                               input logic [2:0] cnt, input logic we,
                                               input logic signed [15:0] x,
                                               input logic signed [15:0] y, input logic lst);
        return {off, bytes, cnt, we, x, y, lst};
    endfunction

    function automatic stim_row_t item_row(input logic cmd, input logic signed [15:0] xs,
                                           input logic signed [15:0] ys,
                                           input logic signed [15:0] xe,
                                           input logic signed [15:0] ye);
        stim_row_t row;
        row.kind      = ROW_ITEM;
        row.reg_index = REG_SURFACE_WIDTH;
        row.reg_data  = '0;
        row.cmd       = cmd;
        row.xs        = xs;
        row.ys        = ys;
        row.xe        = xe;
        row.ye        = ye;
        row.typed     = 1'b0;
        row.want      = '0;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic signed [15:0] x,
                                            input logic signed [15:0] y,
                                            input pixel_word_t want);
        stim_row_t row;
        row       = item_row(CMD_START, x, y, x, y);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input logic [2:0] idx, input logic [31:0] data);
        stim_row_t row;
        row           = item_row(CMD_START, '0, '0, '0, '0);
        row.kind      = ROW_CFG;
        row.reg_index = idx;
        row.reg_data  = data;
        return row;
    endfunction

    // Take one command through the line walker; has_pixel is low when nothing comes out.
    function automatic void rasterize_step(input logic cmd, input logic signed [15:0] xs,
                                           input logic signed [15:0] ys,
                                           input logic signed [15:0] xe,
                                           input logic signed [15:0] ye,
                                           output bit has_pixel, output pixel_word_t px);
        int          dx;
        int          dy;
        int          e2;
        int          wc;
        int          hc;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic [7:0]  t;
        logic [31:0] bytes;
        logic [2:0]  count;
        bit          fmt_ok;
        bit          on_surface;
        longint      off;
        has_pixel = 1'b0;
        px        = '0;
        if (cmd == CMD_START)
        begin
            walk_x    = xs;
            walk_y    = ys;
            walk_tx   = xe;
            walk_ty   = ye;
            dx        = walk_tx - walk_x;
            dy        = walk_ty - walk_y;
            span_x    = (dx < 0) ? -dx : dx;
            span_y    = (dy < 0) ? -dy : dy;
            step_left = !(walk_x < walk_tx);
            step_up   = !(walk_y < walk_ty);
            err_term  = span_x - span_y;
        end
        else
        begin
            if (line_done)
                return;
            e2 = 2 * err_term;
            if (e2 > -span_y)
            begin
                err_term -= span_y;
                walk_x   += step_left ? -1 : 1;
            end
            if (e2 < span_x)
            begin
                err_term += span_x;
                walk_y   += step_up ? -1 : 1;
            end
        end
        line_done = (walk_x == walk_tx) && (walk_y == walk_ty);

        {a, b, g, r} = shadow_cfg.draw_color;
        if (shadow_cfg.source_order)
        begin
            t = r;
            r = b;
            b = t;
        end
        wc     = (shadow_cfg.surface_width > MAX_DIM) ? int'(MAX_DIM)
                                                      : int'(shadow_cfg.surface_width);
        hc     = (shadow_cfg.surface_height > MAX_DIM) ? int'(MAX_DIM)
                                                       : int'(shadow_cfg.surface_height);
        fmt_ok = 1'b1;
        case (shadow_cfg.dest_format)
            FMT_INDEX8:
            begin
                bytes = {24'd0, shadow_cfg.palette_index};
                count = 3'd1;
            end
            FMT_RGB24:
            begin
                bytes = {8'd0, b, g, r};
                count = 3'd3;
            end
            FMT_BGR24:
            begin
                bytes = {8'd0, r, g, b};
                count = 3'd3;
            end
            FMT_RGBA32:
            begin
                bytes = {a, b, g, r};
                count = 3'd4;
            end
            default:
            begin
                bytes  = '0;
                count  = 3'd1;
                fmt_ok = 1'b0;
            end
        endcase
        on_surface = walk_x >= 0 && walk_y >= 0 && walk_x < wc && walk_y < hc;
        off        = 0;
        if (fmt_ok && on_surface)
            off = (longint'(wc) * walk_y + walk_x) * count;

        px.byte_offset  = off[25:0];
        px.pixel_bytes  = bytes;
        px.byte_count   = count;
        px.write_enable = fmt_ok && on_surface;
        px.pixel_x      = walk_x[15:0];
        px.pixel_y      = walk_y[15:0];
        px.last         = line_done;
        has_pixel       = 1'b1;
    endfunction

    // Offer one command in bursts; called and returning at a falling edge.
    task automatic offer_item(input logic cmd, input logic signed [15:0] xs,
                              input logic signed [15:0] ys, input logic signed [15:0] xe,
                              input logic signed [15:0] ye, input bit typed,
                              input pixel_word_t typed_px);
        bit          has_px;
        pixel_word_t px;
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(5, 1)) @(negedge clk);
            burst_left = $urandom_range(24, 1);
        end
        push    <= 1'b1;
        command <= cmd;
        x_start <= xs;
        y_start <= ys;
        x_end   <= xe;
        y_end   <= ye;
        @(posedge clk);
        while (full)
            @(posedge clk);
        rasterize_step(cmd, xs, ys, xe, ye, has_px, px);
        if (cmd == CMD_START)
            lines_started++;
        if (has_px)
        begin
            pixel_expect_q.push_back(typed ? typed_px : px);
            pixels_expected++;
        end
        burst_left--;
        @(negedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_SURFACE_WIDTH:  shadow_cfg.surface_width  = data[12:0];
            REG_SURFACE_HEIGHT: shadow_cfg.surface_height = data[12:0];
            REG_DEST_FORMAT:    shadow_cfg.dest_format    = data[2:0];
            REG_SOURCE_ORDER:   shadow_cfg.source_order   = data[0];
            REG_DRAW_COLOR:     shadow_cfg.draw_color     = data;
            REG_PALETTE_INDEX:  shadow_cfg.palette_index  = data[7:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Hold the input and let every pending pixel and walker step retire.
    task automatic drain_block();
        push <= 1'b0;
        burst_left = 0;
        while (pixel_expect_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            pop <= 1'b0;
            hold_left--;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            pop <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                pop_mode  = $urandom_range(3, 0);
                mode_left = $urandom_range(64, 8);
            end
            mode_left--;
            case (pop_mode)
                0:       pop <= 1'b1;
                1:       pop <= ($urandom_range(1, 0) == 0);
                2:       pop <= ($urandom_range(3, 0) == 0);
                default: pop <= ($urandom_range(3, 0) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : pixel_check
        pixel_word_t got;
        pixel_word_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                got = {byte_offset, pixel_bytes, byte_count, write_enable, pixel_x, pixel_y,
                       last};
                pixels_checked++;
                if (write_enable)
                    pixels_written++;
                if (pixel_expect_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: unexpected pixel x=%0d y=%0d off=%0d",
                                 pixel_x, pixel_y, byte_offset);
                end
                else
                begin
                    want = pixel_expect_q.pop_front();
                    if (got.byte_offset !== want.byte_offset ||
                        got.pixel_bytes !== want.pixel_bytes ||
                        got.byte_count !== want.byte_count ||
                        got.write_enable !== want.write_enable ||
                        got.pixel_x !== want.pixel_x ||
                        got.pixel_y !== want.pixel_y ||
                        got.last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display("mismatch at pixel %0d", pixels_checked);
                            $display("exp off=%0d px=%08h cnt=%0d we=%0b x=%0d y=%0d last=%0b",
                                     want.byte_offset, want.pixel_bytes, want.byte_count,
                                     want.write_enable, want.pixel_x, want.pixel_y, want.last);
                            $display("got off=%0d px=%08h cnt=%0d we=%0b x=%0d y=%0d last=%0b",
                                     got.byte_offset, got.pixel_bytes, got.byte_count,
                                     got.write_enable, got.pixel_x, got.pixel_y, got.last);
                        end
                    end
                end
            end
            if (push && full)
                full_stalls++;
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial
    begin : watchdog
        wait (rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int          phase;
        int          phase_goal;
        int          wc;
        int          hc;
        int          x0;
        int          y0;
        int          x1;
        int          y1;
        int          steps;
        int          n;
        int          kind;
        bit          cfg_open;
        logic [12:0] width_val;
        logic [12:0] height_val;
        logic [2:0]  fmt_val;
        logic [31:0] color_val;
        logic [7:0]  palette_val;

        clk          = 1'b0;
        rst_n        = 1'b0;
        push         = 1'b0;
        command      = CMD_START;
        x_start      = '0;
        y_start      = '0;
        x_end        = '0;
        y_end        = '0;
        pop          = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_SURFACE_WIDTH;
        cfg_data     = '0;
        burst_left   = 0;
        hold_left    = 0;
        hold_request = 1'b0;
        mode_left    = 0;
        pop_mode     = 0;
        idle_cycles  = 0;
        fail_count   = 0;
        cfg_open     = 1'b0;

        shadow_cfg.surface_width  = 13'd640;
        shadow_cfg.surface_height = 13'd480;
        shadow_cfg.dest_format    = FMT_RGBA32;
        shadow_cfg.source_order   = 1'b0;
        shadow_cfg.draw_color     = '0;
        shadow_cfg.palette_index  = '0;
        walk_x    = 0;
        walk_y    = 0;
        walk_tx   = 0;
        walk_ty   = 0;
        span_x    = 0;
        span_y    = 0;
        err_term  = 0;
        step_left = 1'b0;
        step_up   = 1'b0;
        line_done = 1'b1;

        directed_rows.push_back(item_row(CMD_ADVANCE, 16'sh5A5A, 16'shA5A5, 16'sh0F0F, 16'shF0F0));
        directed_rows.push_back(typed_row(16'sd0, 16'sd0,
                                pixel_word(26'd0, 32'd0, 3'd4, 1'b1, 16'sd0, 16'sd0, 1'b1)));
        directed_rows.push_back(typed_row(16'sd639, 16'sd479,
                                pixel_word(26'd1228796, 32'd0, 3'd4, 1'b1, 16'sd639, 16'sd479,
                                           1'b1)));
        directed_rows.push_back(typed_row(16'sd640, 16'sd0,
                                pixel_word(26'd0, 32'd0, 3'd4, 1'b0, 16'sd640, 16'sd0, 1'b1)));
        directed_rows.push_back(typed_row(16'sh8000, 16'sd32767,
                                pixel_word(26'd0, 32'd0, 3'd4, 1'b0, 16'sh8000, 16'sd32767,
                                           1'b1)));
        directed_rows.push_back(item_row(CMD_START, 16'sh8000, 16'sh8000, 16'sd32767, 16'sd32767));
        directed_rows.push_back(item_row(CMD_ADVANCE, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
        directed_rows.push_back(item_row(CMD_ADVANCE, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF));
        directed_rows.push_back(item_row(CMD_START, 16'sd0, 16'sd0, 16'sd3, 16'sd1));
        repeat (4)
            directed_rows.push_back(item_row(CMD_ADVANCE, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
        directed_rows.push_back(item_row(CMD_START, 16'sd2, 16'sd5, 16'sd0, 16'sd0));
        repeat (2)
            directed_rows.push_back(item_row(CMD_ADVANCE, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
        directed_rows.push_back(item_row(CMD_START, 16'sd10, 16'sd10, 16'sd12, 16'sd8));
        directed_rows.push_back(item_row(CMD_ADVANCE, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
        directed_rows.push_back(cfg_row(REG_DRAW_COLOR, 32'h4433_2211));
        directed_rows.push_back(item_row(CMD_START, 16'sd1, 16'sd1, 16'sd2, 16'sd1));
        directed_rows.push_back(item_row(CMD_ADVANCE, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
        directed_rows.push_back(cfg_row(REG_SOURCE_ORDER, 32'd1));
        directed_rows.push_back(cfg_row(REG_DEST_FORMAT, {29'd0, FMT_RGB24}));
        directed_rows.push_back(item_row(CMD_START, 16'sd3, 16'sd2, 16'sd3, 16'sd2));
        directed_rows.push_back(cfg_row(REG_DEST_FORMAT, {29'd0, FMT_BGR24}));
        directed_rows.push_back(item_row(CMD_START, 16'sd4, 16'sd2, 16'sd4, 16'sd2));
        directed_rows.push_back(cfg_row(REG_DEST_FORMAT, {29'd0, FMT_INDEX8}));
        directed_rows.push_back(cfg_row(REG_PALETTE_INDEX, 32'hA5));
        directed_rows.push_back(item_row(CMD_START, 16'sd5, 16'sd2, 16'sd5, 16'sd2));
        directed_rows.push_back(cfg_row(REG_DEST_FORMAT, {29'd0, FMT_NONE}));
        directed_rows.push_back(typed_row(16'sd5, 16'sd5,
                                pixel_word(26'd0, 32'd0, 3'd1, 1'b0, 16'sd5, 16'sd5, 1'b1)));
        directed_rows.push_back(cfg_row(REG_DEST_FORMAT, {29'd0, FMT_RGBA32}));
        directed_rows.push_back(cfg_row(REG_SURFACE_WIDTH, 32'd8191));
        directed_rows.push_back(cfg_row(REG_SURFACE_HEIGHT, 32'd0));
        directed_rows.push_back(cfg_row(REG_SPARE_LO, 32'hFFFF_FFFF));
        directed_rows.push_back(cfg_row(REG_SPARE_HI, 32'h0));
        directed_rows.push_back(item_row(CMD_START, 16'sd7, 16'sd0, 16'sd7, 16'sd0));
        directed_rows.push_back(cfg_row(REG_SURFACE_HEIGHT, 32'd4096));
        directed_rows.push_back(item_row(CMD_START, 16'sd4095, 16'sd4095, 16'sd4095, 16'sd4095));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                if (!cfg_open)
                    drain_block();
                write_register(directed_rows[i].reg_index, directed_rows[i].reg_data);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                offer_item(directed_rows[i].cmd, directed_rows[i].xs, directed_rows[i].ys,
                           directed_rows[i].xe, directed_rows[i].ye, directed_rows[i].typed,
                           directed_rows[i].want);
            end
        end

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_block();
            case (phase)
                0:
                begin
                    width_val  = 13'd1;
                    height_val = 13'd1;
                    fmt_val    = FMT_RGBA32;
                end
                1:
                begin
                    width_val  = 13'd4096;
                    height_val = 13'd4096;
                    fmt_val    = FMT_INDEX8;
                end
                2:
                begin
                    width_val  = 13'd8191;
                    height_val = 13'd8191;
                    fmt_val    = FMT_RGB24;
                end
                3:
                begin
                    width_val  = 13'd0;
                    height_val = 13'($urandom_range(64, 1));
                    fmt_val    = FMT_BGR24;
                end
                4:
                begin
                    width_val  = 13'($urandom_range(64, 1));
                    height_val = 13'($urandom_range(64, 0));
                    fmt_val    = FMT_NONE;
                end
                default:
                begin
                    width_val  = 13'($urandom);
                    height_val = 13'($urandom);
                    fmt_val    = 3'($urandom);
                end
            endcase
            color_val   = (phase == 0) ? 32'h0 : (phase == 1) ? 32'hFFFF_FFFF : 32'($urandom);
            palette_val = (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF : 8'($urandom);

            write_register(REG_SURFACE_WIDTH, ($urandom & 32'hFFFF_E000) | {19'd0, width_val});
            write_register(REG_SURFACE_HEIGHT, ($urandom & 32'hFFFF_E000) | {19'd0, height_val});
            write_register(REG_DEST_FORMAT, ($urandom & 32'hFFFF_FFF8) | {29'd0, fmt_val});
            write_register(REG_SOURCE_ORDER, ($urandom & 32'hFFFF_FFFE) | 32'(phase % 2));
            write_register(REG_DRAW_COLOR, color_val);
            write_register(REG_PALETTE_INDEX, ($urandom & 32'hFFFF_FF00) | {24'd0, palette_val});
            write_register((phase % 2 == 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
            cfg_valid <= 1'b0;

            if (phase == 2)
                hold_request = 1'b1;

            wc = (width_val > MAX_DIM) ? int'(MAX_DIM) : int'(width_val);
            hc = (height_val > MAX_DIM) ? int'(MAX_DIM) : int'(height_val);
            if (wc == 0)
                wc = 8;
            if (hc == 0)
                hc = 8;

            phase_goal = pixels_expected + PIXELS_PER_PHASE;
            while (pixels_expected < phase_goal)
            begin
                kind = $urandom_range(99, 0);
                if (kind < 95)
                begin
                    if (kind < 87)
                    begin
                        x0 = int'($urandom_range(wc + 15, 0)) - 8;
                        y0 = int'($urandom_range(hc + 15, 0)) - 8;
                        x1 = x0 + int'($urandom_range(40, 0)) - 20;
                        y1 = y0 + int'($urandom_range(40, 0)) - 20;
                    end
                    else
                    begin
                        x0 = int'(16'sh8000 ^ 16'($urandom)) - 32768;
                        y0 = int'(16'sh8000 ^ 16'($urandom)) - 32768;
                        x1 = int'(16'sh8000 ^ 16'($urandom)) - 32768;
                        y1 = int'(16'sh8000 ^ 16'($urandom)) - 32768;
                    end
                    steps = ((x1 > x0) ? x1 - x0 : x0 - x1);
                    if (((y1 > y0) ? y1 - y0 : y0 - y1) > steps)
                        steps = (y1 > y0) ? y1 - y0 : y0 - y1;
                    if (kind < 75)
                        n = steps + $urandom_range(2, 0);
                    else if (kind < 87)
                        n = (steps == 0) ? 0 : $urandom_range(steps - 1, 0);
                    else
                        n = $urandom_range(3, 0);
                    offer_item(CMD_START, 16'(x0), 16'(y0), 16'(x1), 16'(y1), 1'b0, '0);
                end
                else
                    n = $urandom_range(3, 1);
                repeat (n)
                    offer_item(CMD_ADVANCE, 16'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom), 1'b0, '0);
            end
        end

        drain_block();
        fail_count += pixel_expect_q.size();

        $display("run covered %0d lines and %0d checked pixels (%0d written) over %0d settings",
                 lines_started, pixels_checked, pixels_written, NUM_PHASES + 1);
        $display("input held off by a full block for %0d cycles; %0d mismatches",
                 full_stalls, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
